>>> src/ctd_pkg.sv
// Shared types and constants for the CER token decoder.
// No dependencies; imported by cer_token_decoder_unit.
`default_nettype none

package ctd_pkg;

  // Nesting bound for indefinite string segments, and size bound for integer types
  localparam int MAX_NEST_DEPTH = 4;
  localparam int MAX_INT_BYTES  = 4;

  // Result queue depth
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_W    = $clog2(RES_DEPTH);
  localparam int RES_CNT_W    = RES_PTR_W + 1;

  localparam logic [7:0]  CODE_ERR    = 8'hFF;
  localparam logic [7:0]  LEN_INDEF   = 8'h80;
  localparam logic [4:0]  TAG_EOC     = 5'd0;
  localparam logic [4:0]  TAG_SEQ     = 5'd16;
  localparam logic [31:0] STRING_TAGS = 32'h7FBC_1010;
  localparam logic [31:0] INT_TAGS    = 32'h0000_0406;

  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_TOKEN   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         token_code;
    logic signed [31:0] int_value;
    logic [7:0]         content_byte;
    logic [31:0]        consumed;
    logic               last_of_run;
  } res_t;

  function automatic res_t make_res(logic kind, logic [7:0] code, logic [31:0] ival,
                                    logic [7:0] cbyte, logic [31:0] cons);
    res_t r;
    r.kind         = kind;
    r.token_code   = code;
    r.int_value    = ival;
    r.content_byte = cbyte;
    r.consumed     = cons;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/cer_token_decoder_unit.sv
// CER token decoder top level: byte parser state and result queue.
// Depends on ctd_pkg.
`default_nettype none

// Decodes an ASN.1 CER/BER byte stream, one byte word per accepted cycle. Each
// byte is parsed in a single pass against the parser state and gives zero, one
// or two result words, which are pushed into a 4-entry result queue. The byte
// side takes a word in every cycle while the queue has two free entries, so
// byte_stall rises only when the token side falls behind; the queue drains one
// word per cycle while token_stall is low. A byte giving two results (the last
// content byte of a string together with its finished token, or a content byte
// followed by a truncation error) puts two words on the token port, so sustained
// throughput is one byte per cycle except around those bytes. Errors report token_code
// 255 and return the parser to its reset state; the next byte is read as a tag byte.
module cer_token_decoder_unit
  import ctd_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  // byte side
  input  wire               byte_valid,
  output logic              byte_stall,
  input  wire  [7:0]        data_byte,
  input  wire               end_of_buffer,
  // token side
  output logic              token_valid,
  input  wire               token_stall,
  output logic              kind,
  output logic [7:0]        token_code,
  output logic signed [31:0] int_value,
  output logic [7:0]        content_byte,
  output logic [31:0]       consumed,
  output logic              last_of_run
);

  typedef enum logic [2:0] {
    PH_TAG,   // waiting for a tag byte
    PH_LEN0,  // first length byte
    PH_LENX,  // long-form length bytes
    PH_INT,   // integer content
    PH_STR    // string content
  } phase_t;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  tag_byte, tag_byte_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [31:0] content_bytes_left, content_bytes_left_next;
  logic [31:0] integer_accumulator, integer_accumulator_next;
  logic [31:0] position_count, position_count_next;
  logic [2:0]  nest_depth, nest_depth_next;
  logic        seg_end, seg_end_next;

  // Result queue
  res_t                 res_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] res_count;

  logic byte_accept, token_accept;

  // Per-byte decode signals
  logic        ok, trunc, restart;
  logic [31:0] pos_base, pos_new;
  logic        hdr_go, hdr_indef;
  logic [31:0] hdr_len, hdr_lval;
  logic [1:0]  tag_cls;
  logic [4:0]  tag_num;
  logic        tag_cons;
  logic [31:0] lacc_shift, iacc_shift, int_ext, cbl_dec;
  logic [2:0]  lbl_dec, nest_dec;
  logic        ea_valid, eb_valid;
  res_t        ea_res, eb_res, err_res;
  res_t        res0, res1;
  logic [1:0]  n_res;

  assign byte_stall   = (res_count > RES_CNT_W'(RES_DEPTH - 2));
  assign byte_accept  = byte_valid && !byte_stall;
  assign token_valid  = (res_count != '0);
  assign token_accept = token_valid && !token_stall;

  assign tag_cls  = tag_byte[7:6];
  assign tag_num  = tag_byte[4:0];
  assign tag_cons = tag_byte[5];

  assign pos_base   = (phase == PH_TAG && nest_depth == '0) ? '0 : position_count;
  assign pos_new    = (pos_base == '1) ? pos_base : pos_base + 32'd1;
  assign lacc_shift = {length_accumulator[23:0], data_byte};
  assign iacc_shift = {integer_accumulator[23:0], data_byte};
  assign lbl_dec    = length_bytes_left - 3'd1;
  assign cbl_dec    = content_bytes_left - 32'd1;
  assign nest_dec   = nest_depth - 3'd1;
  assign hdr_lval   = hdr_indef ? '1 : hdr_len;
  assign err_res    = make_res(KIND_TOKEN, CODE_ERR, '0, '0, '0);

  // Sign extension of a short integer by its content length
  always_comb begin
    case (length_accumulator[2:0])
      3'd1:    int_ext = {{24{iacc_shift[7]}}, iacc_shift[7:0]};
      3'd2:    int_ext = {{16{iacc_shift[15]}}, iacc_shift[15:0]};
      3'd3:    int_ext = {{8{iacc_shift[23]}}, iacc_shift[23:0]};
      default: int_ext = iacc_shift;
    endcase
  end

  // Length field decode: find where the header completes
  always_comb begin
    hdr_go    = 1'b0;
    hdr_indef = 1'b0;
    hdr_len   = '0;
    if (phase == PH_LEN0) begin
      if (data_byte == LEN_INDEF) begin
        hdr_go    = 1'b1;
        hdr_indef = 1'b1;
      end else if (!data_byte[7]) begin
        hdr_go  = 1'b1;
        hdr_len = {24'd0, data_byte};
      end
    end else if (phase == PH_LENX) begin
      if (lbl_dec == '0 && !lacc_shift[31]) begin
        hdr_go  = 1'b1;
        hdr_len = lacc_shift;
      end
    end
  end

  // Main parse step
  always_comb begin
    phase_next               = phase;
    tag_byte_next            = tag_byte;
    length_bytes_left_next   = length_bytes_left;
    length_accumulator_next  = length_accumulator;
    content_bytes_left_next  = content_bytes_left;
    integer_accumulator_next = integer_accumulator;
    position_count_next      = pos_new;
    nest_depth_next          = nest_depth;
    seg_end_next             = seg_end;
    ok       = 1'b1;
    ea_valid = 1'b0;
    eb_valid = 1'b0;
    ea_res   = err_res;
    eb_res   = make_res(KIND_TOKEN, {3'd0, tag_num}, '0, '0, pos_new);

    case (phase)
      PH_TAG: begin
        if (nest_depth == '0) begin
          tag_byte_next = data_byte;
          seg_end_next  = 1'b0;
        end else begin
          if (data_byte[7:6] != 2'd0 ||
              (data_byte[4:0] != TAG_EOC && data_byte[4:0] != tag_num))
            ok = 1'b0;
          seg_end_next = (data_byte[4:0] == TAG_EOC);
        end
        phase_next = PH_LEN0;
      end
      PH_LEN0: begin
        if (!hdr_go) begin
          if (data_byte[6:0] > 7'd4) begin
            ok = 1'b0;
          end else begin
            length_bytes_left_next  = data_byte[2:0];
            length_accumulator_next = '0;
            phase_next              = PH_LENX;
          end
        end
      end
      PH_LENX: begin
        length_accumulator_next = lacc_shift;
        length_bytes_left_next  = lbl_dec;
        if (lbl_dec == '0 && lacc_shift[31])
          ok = 1'b0;
      end
      PH_INT: begin
        integer_accumulator_next = iacc_shift;
        content_bytes_left_next  = cbl_dec;
        if (cbl_dec == '0) begin
          ea_valid   = 1'b1;
          ea_res     = make_res(KIND_TOKEN, {3'd0, tag_num}, int_ext, '0, pos_new);
          phase_next = PH_TAG;
        end
      end
      PH_STR: begin
        ea_valid = 1'b1;
        ea_res   = make_res(KIND_CONTENT, {3'd0, tag_num}, '0, data_byte, pos_new);
        content_bytes_left_next = cbl_dec;
        if (cbl_dec == '0) begin
          eb_valid   = (nest_depth == '0);
          phase_next = PH_TAG;
        end
      end
      default: ok = 1'b0;
    endcase

    // Header complete: classify the token
    if (hdr_go) begin
      length_accumulator_next = hdr_len;
      phase_next              = PH_TAG;
      if (nest_depth != '0) begin
        if (seg_end) begin
          if (hdr_indef || hdr_len != '0) begin
            ok = 1'b0;
          end else begin
            nest_depth_next = nest_dec;
            if (nest_dec == '0) begin
              ea_valid = 1'b1;
              ea_res   = make_res(KIND_TOKEN, {3'd0, tag_num}, '0, '0, pos_new);
            end
          end
        end else if (hdr_indef) begin
          if (nest_depth >= 3'(MAX_NEST_DEPTH))
            ok = 1'b0;
          else
            nest_depth_next = nest_depth + 3'd1;
        end else if (hdr_len != '0) begin
          content_bytes_left_next = hdr_len;
          phase_next              = PH_STR;
        end
      end else if (tag_cls != 2'd0) begin
        if (!tag_cons) begin
          ok = 1'b0;
        end else begin
          ea_valid = 1'b1;
          ea_res   = make_res(KIND_TOKEN, {tag_cls, 1'b0, tag_num}, hdr_lval, '0, pos_new);
        end
      end else if (tag_num == TAG_SEQ) begin
        if (!tag_cons) begin
          ok = 1'b0;
        end else begin
          ea_valid = 1'b1;
          ea_res   = make_res(KIND_TOKEN, {3'd0, tag_num}, hdr_lval, '0, pos_new);
        end
      end else if (tag_num == TAG_EOC) begin
        if (hdr_indef || hdr_len != '0) begin
          ok = 1'b0;
        end else begin
          ea_valid = 1'b1;
          ea_res   = make_res(KIND_TOKEN, '0, '0, '0, pos_new);
        end
      end else if (INT_TAGS[tag_num]) begin
        if (tag_cons || hdr_indef || hdr_len == '0 || hdr_len > 32'(MAX_INT_BYTES)) begin
          ok = 1'b0;
        end else begin
          content_bytes_left_next  = hdr_len;
          integer_accumulator_next = '0;
          phase_next               = PH_INT;
        end
      end else if (STRING_TAGS[tag_num]) begin
        if (hdr_indef) begin
          nest_depth_next = 3'd1;
        end else if (hdr_len == '0) begin
          ea_valid = 1'b1;
          ea_res   = make_res(KIND_TOKEN, {3'd0, tag_num}, '0, '0, pos_new);
        end else begin
          content_bytes_left_next = hdr_len;
          phase_next              = PH_STR;
        end
      end else begin
        ok = 1'b0;
      end
    end

    // Truncated token at end of buffer
    trunc   = ok && end_of_buffer && (phase_next != PH_TAG || nest_depth_next != '0);
    restart = !ok || trunc;
    if (restart) begin
      phase_next               = PH_TAG;
      tag_byte_next            = '0;
      length_bytes_left_next   = '0;
      length_accumulator_next  = '0;
      content_bytes_left_next  = '0;
      integer_accumulator_next = '0;
      position_count_next      = '0;
      nest_depth_next          = '0;
      seg_end_next             = 1'b0;
    end
  end

  // Assemble the results of this byte in order; the last one is flagged
  always_comb begin
    res0  = err_res;
    res1  = err_res;
    n_res = 2'd0;
    if (!ok) begin
      n_res = 2'd1;
    end else if (ea_valid) begin
      res0 = ea_res;
      if (eb_valid) begin
        res1  = eb_res;
        n_res = 2'd2;
      end else if (trunc) begin
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (trunc) begin
      n_res = 2'd1;
    end
    if (n_res == 2'd2)
      res1.last_of_run = 1'b1;
    else
      res0.last_of_run = 1'b1;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_TAG;
      tag_byte            <= '0;
      length_bytes_left   <= '0;
      length_accumulator  <= '0;
      content_bytes_left  <= '0;
      integer_accumulator <= '0;
      position_count      <= '0;
      nest_depth          <= '0;
      seg_end             <= 1'b0;
    end else if (byte_accept) begin
      phase               <= phase_next;
      tag_byte            <= tag_byte_next;
      length_bytes_left   <= length_bytes_left_next;
      length_accumulator  <= length_accumulator_next;
      content_bytes_left  <= content_bytes_left_next;
      integer_accumulator <= integer_accumulator_next;
      position_count      <= position_count_next;
      nest_depth          <= nest_depth_next;
      seg_end             <= seg_end_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      if (n_res != 2'd0)
        res_mem[wr_ptr] <= res0;
      if (n_res == 2'd2)
        res_mem[wr_ptr + RES_PTR_W'(1)] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (byte_accept)
        wr_ptr <= wr_ptr + RES_PTR_W'(n_res);
      if (token_accept)
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      res_count <= res_count + (byte_accept ? RES_CNT_W'(n_res) : '0)
                   - (token_accept ? RES_CNT_W'(1) : '0);
    end
  end

  assign kind         = res_mem[rd_ptr].kind;
  assign token_code   = res_mem[rd_ptr].token_code;
  assign int_value    = res_mem[rd_ptr].int_value;
  assign content_byte = res_mem[rd_ptr].content_byte;
  assign consumed     = res_mem[rd_ptr].consumed;
  assign last_of_run  = res_mem[rd_ptr].last_of_run;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // Any error returns the parser to its idle state
  assert property (@(posedge clk) disable iff (rst)
    (byte_accept && restart) |=> (phase == PH_TAG && nest_depth == '0 && position_count == '0))
    else $error("parser not restarted after error");

  // Nesting stays within its bound
  assert property (@(posedge clk) disable iff (rst)
    nest_depth <= 3'(MAX_NEST_DEPTH))
    else $error("nest depth out of range");

  // Long-form length always has bytes still to come
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LENX) |-> (length_bytes_left != '0))
    else $error("long length with no bytes left");

  // Content words never carry the error code
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && kind == KIND_CONTENT) |-> (token_code != CODE_ERR))
    else $error("content word with error code");

endmodule

`default_nettype wire
